/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that prop holds at every rising clock edge outside reset.
`define DRD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Check that prop never holds outside reset.
`define DRD_ASSERT_NEVER(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(prop)) else $error(msg);
`else
`define DRD_ASSERT(label, clk, rst_n, prop, msg)
`define DRD_ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

/* hw/rtl/drd_pkg.sv */
// Constants, register indexes and helpers of the detection row decoder.
package drd_pkg;

    localparam int MAX_CLASSES    = 128;
    localparam int FRACTION_BITS  = 12;
    localparam int MAX_IMAGE_SIZE = 4096;

    localparam int VALUE_W  = 24;
    localparam int CLASS_W  = 7;
    localparam int POS_W    = 8;
    localparam int DIM_W    = 13;
    localparam int COORD_W  = 12;
    localparam int SCALE_W  = 20;
    localparam int THR_W    = 13;
    localparam int MUL_W    = DIM_W + FRACTION_BITS;   // unsigned multiplier operand
    localparam int PROD_W   = VALUE_W + MUL_W + 1;     // signed product
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int OUT_DATA_W = 88;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_HORIZ     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_VERT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THRESHOLD = 3'd5;

    localparam logic [POS_W-1:0] POS_MIN_LAST = POS_W'(4);
    localparam logic [POS_W-1:0] POS_MAX_LAST = POS_W'(3 + MAX_CLASSES);

    localparam logic signed [VALUE_W-1:0] FIX_ONE = VALUE_W'(1 << FRACTION_BITS);

    // Saturate an image size register into 1..MAX_IMAGE_SIZE
    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0) begin
            r = DIM_W'(1);
        end else if (d > DIM_W'(MAX_IMAGE_SIZE)) begin
            r = DIM_W'(MAX_IMAGE_SIZE);
        end
        return r;
    endfunction

endpackage

/* hw/rtl/detection_row_decoder.sv */
// Top level of the detection row decoder: row scan, scaling pipeline, clamping.
//
// Usage:
//   Slave stream (i_s_axis_*) carries one row value per transfer, signed
//   Q11.12: center x, center y, width, height, then row_length-4 class scores.
//   Master stream (o_m_axis_*) carries one box per kept row: best class,
//   best score, left, top, width, height in pixels.
//   Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data);
//   write it only while no row is in flight.
// Throughput: one value per cycle while o_s_axis_tready is high; rows follow each other with no gap.
// Pipeline: after the transfer of the last row value, the box of a row passes
//   the stage 1 latch, product, divide/clamp and output registers in that
//   order. Rows whose best score is below the threshold drop out at the scan
//   and cause no transfer.
// Stalls: each of the four pipeline registers holds its content while the
//   one after it is full and not moving; the input ready falls only when
//   the whole pipeline is full, so a waiting box does not block new values.
// Reset (i_rst_n low, synchronous): registers return to their reset
//   values, the row position and running argmax clear and all pipeline
//   stages empty.
module detection_row_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // value
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [drd_pkg::VALUE_W-1:0]         i_s_axis_tdata,
    // class_index, best_score, box_left, box_top, box_width, box_height, zero pad
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [drd_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [drd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [drd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import drd_pkg::*;
    `include "assert_macros.svh"

    // Configuration registers
    logic [POS_W-1:0]   r_row_length;
    logic [DIM_W-1:0]   r_image_width;
    logic [DIM_W-1:0]   r_image_height;
    logic [SCALE_W-1:0] r_scale_h;
    logic [SCALE_W-1:0] r_scale_v;
    logic [THR_W-1:0]   r_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length   <= POS_W'(5);
            r_image_width  <= DIM_W'(640);
            r_image_height <= DIM_W'(480);
            r_scale_h      <= SCALE_W'(8192);
            r_scale_v      <= SCALE_W'(6144);
            r_threshold    <= THR_W'(614);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROW_LENGTH:      r_row_length   <= i_cfg_data[POS_W-1:0];
                CFG_IMAGE_WIDTH:     r_image_width  <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT:    r_image_height <= i_cfg_data[DIM_W-1:0];
                CFG_SCALE_HORIZ:     r_scale_h      <= i_cfg_data[SCALE_W-1:0];
                CFG_SCALE_VERT:      r_scale_v      <= i_cfg_data[SCALE_W-1:0];
                CFG_SCORE_THRESHOLD: r_threshold    <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline handshake: each stage moves when the next is empty or moving
    logic r_v1, r_v2, r_v3, r_v4;
    logic adv1, adv2, adv3, adv4;
    logic in_xfer;

    assign adv4 = !r_v4 || i_m_axis_tready;
    assign adv3 = !r_v3 || adv4;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign o_s_axis_tready = adv1;
    assign in_xfer = i_s_axis_tvalid && adv1;

    // Row scan: position, box fields, running argmax
    logic        [POS_W-1:0]   r_pos, n_pos;
    logic signed [VALUE_W-1:0] r_box [4];
    logic signed [VALUE_W-1:0] r_best, n_best;
    logic        [CLASS_W-1:0] r_class, n_class;
    logic        [POS_W-1:0]   last_pos;
    logic signed [VALUE_W-1:0] in_val;
    logic                      row_end;
    logic                      row_keep;

    assign in_val = $signed(i_s_axis_tdata);

    always_comb begin
        if (r_row_length <= POS_MIN_LAST) begin
            last_pos = POS_MIN_LAST;
        end else if (r_row_length > POS_MAX_LAST) begin
            last_pos = POS_MAX_LAST;
        end else begin
            last_pos = r_row_length - POS_W'(1);
        end
        n_best  = r_best;
        n_class = r_class;
        if (r_pos == POS_MIN_LAST) begin
            n_best  = in_val;
            n_class = '0;
        end else if (r_pos > POS_MIN_LAST && in_val > r_best) begin
            n_best  = in_val;
            n_class = CLASS_W'(r_pos - POS_MIN_LAST);
        end
        row_end  = (r_pos >= last_pos);
        n_pos    = row_end ? '0 : r_pos + POS_W'(1);
        // negative scores stay negative against the unsigned threshold
        row_keep = ($signed({n_best[VALUE_W-1], n_best}) >=
                    $signed({{(VALUE_W - THR_W + 1){1'b0}}, r_threshold}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_best  <= '0;
            r_class <= '0;
            for (int k = 0; k < 4; k++) begin
                r_box[k] <= '0;
            end
        end else if (in_xfer) begin
            r_pos   <= n_pos;
            r_best  <= n_best;
            r_class <= n_class;
            if (r_pos < POS_MIN_LAST) begin
                r_box[r_pos[1:0]] <= in_val;
            end
        end
    end

    // Stage 1: latch the kept row, pick the multipliers
    logic signed [VALUE_W-1:0] r_s1_box [4];
    logic        [MUL_W-1:0]   r_s1_mx, r_s1_my;
    logic        [DIM_W-1:0]   r_s1_w, r_s1_h;
    logic        [CLASS_W-1:0] r_s1_class;
    logic signed [VALUE_W-1:0] r_s1_score;
    logic        [DIM_W-1:0]   img_w, img_h;
    logic                      normalized;

    assign img_w = sat_dim(r_image_width);
    assign img_h = sat_dim(r_image_height);
    assign normalized = (r_box[0] <= FIX_ONE) && (r_box[1] <= FIX_ONE) &&
                        (r_box[2] <= FIX_ONE) && (r_box[3] <= FIX_ONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv1) begin
            r_v1 <= in_xfer && row_end && row_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            for (int k = 0; k < 4; k++) begin
                r_s1_box[k] <= r_box[k];
            end
            r_s1_mx    <= normalized ? {img_w, {FRACTION_BITS{1'b0}}}
                                     : MUL_W'(r_scale_h);
            r_s1_my    <= normalized ? {img_h, {FRACTION_BITS{1'b0}}}
                                     : MUL_W'(r_scale_v);
            r_s1_w     <= img_w;
            r_s1_h     <= img_h;
            r_s1_class <= n_class;
            r_s1_score <= n_best;
        end
    end

    // Stage 2: four products with 2*FRACTION_BITS fraction bits
    // (24 by 26 bit signed multiplies, operands sign-extended to the product width)
    logic signed [PROD_W-1:0]  r_s2_p [4];
    logic        [DIM_W-1:0]   r_s2_w, r_s2_h;
    logic        [CLASS_W-1:0] r_s2_class;
    logic signed [VALUE_W-1:0] r_s2_score;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_s2_p[0]  <= PROD_W'(r_s1_box[0]) * PROD_W'($signed({1'b0, r_s1_mx}));
            r_s2_p[1]  <= PROD_W'(r_s1_box[1]) * PROD_W'($signed({1'b0, r_s1_my}));
            r_s2_p[2]  <= PROD_W'(r_s1_box[2]) * PROD_W'($signed({1'b0, r_s1_mx}));
            r_s2_p[3]  <= PROD_W'(r_s1_box[3]) * PROD_W'($signed({1'b0, r_s1_my}));
            r_s2_w     <= r_s1_w;
            r_s2_h     <= r_s1_h;
            r_s2_class <= r_s1_class;
            r_s2_score <= r_s1_score;
        end
    end

    // Stage 3: truncating divides, clamp left and top into the image
    localparam int EDGE_SH = 2 * FRACTION_BITS + 1;
    localparam int SIZE_SH = 2 * FRACTION_BITS;
    localparam int DIFF_W  = PROD_W + 2;
    localparam int EDGE_W  = DIFF_W - EDGE_SH;
    localparam int SIZE_W  = PROD_W - SIZE_SH;

    logic signed [DIFF_W-1:0]  diff_x, diff_y, bias_x, bias_y;
    logic signed [PROD_W-1:0]  bias_w, bias_h;
    logic signed [EDGE_W-1:0]  q_x, q_y;
    logic        [COORD_W-1:0] n_s3_x, n_s3_y;
    logic        [COORD_W-1:0] r_s3_x, r_s3_y;
    logic signed [SIZE_W-1:0]  r_s3_rw, r_s3_rh;
    logic        [DIM_W-1:0]   r_s3_w, r_s3_h;
    logic        [CLASS_W-1:0] r_s3_class;
    logic signed [VALUE_W-1:0] r_s3_score;

    always_comb begin
        diff_x = (DIFF_W'(r_s2_p[0]) <<< 1) - DIFF_W'(r_s2_p[2]);
        diff_y = (DIFF_W'(r_s2_p[1]) <<< 1) - DIFF_W'(r_s2_p[3]);
        // bias negative values so the shift rounds toward zero
        bias_x = diff_x + (diff_x[DIFF_W-1] ? DIFF_W'((1 << EDGE_SH) - 1) : '0);
        bias_y = diff_y + (diff_y[DIFF_W-1] ? DIFF_W'((1 << EDGE_SH) - 1) : '0);
        bias_w = r_s2_p[2] + (r_s2_p[2][PROD_W-1] ? PROD_W'((1 << SIZE_SH) - 1) : '0);
        bias_h = r_s2_p[3] + (r_s2_p[3][PROD_W-1] ? PROD_W'((1 << SIZE_SH) - 1) : '0);
        q_x = bias_x[DIFF_W-1:EDGE_SH];
        q_y = bias_y[DIFF_W-1:EDGE_SH];
        if (q_x < 0) begin
            n_s3_x = '0;
        end else if (q_x > $signed(EDGE_W'(r_s2_w - DIM_W'(1)))) begin
            n_s3_x = COORD_W'(r_s2_w - DIM_W'(1));
        end else begin
            n_s3_x = q_x[COORD_W-1:0];
        end
        if (q_y < 0) begin
            n_s3_y = '0;
        end else if (q_y > $signed(EDGE_W'(r_s2_h - DIM_W'(1)))) begin
            n_s3_y = COORD_W'(r_s2_h - DIM_W'(1));
        end else begin
            n_s3_y = q_y[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (adv3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_s3_x     <= n_s3_x;
            r_s3_y     <= n_s3_y;
            r_s3_rw    <= bias_w[PROD_W-1:SIZE_SH];
            r_s3_rh    <= bias_h[PROD_W-1:SIZE_SH];
            r_s3_w     <= r_s2_w;
            r_s3_h     <= r_s2_h;
            r_s3_class <= r_s2_class;
            r_s3_score <= r_s2_score;
        end
    end

    // Stage 4: clamp width and height to what is left of the image
    logic [DIM_W-1:0]          room_w, room_h, n_s4_bw, n_s4_bh;
    logic [COORD_W-1:0]        r_s4_x, r_s4_y;
    logic [DIM_W-1:0]          r_s4_bw, r_s4_bh;
    logic [DIM_W-1:0]          r_s4_imgw;
    logic [CLASS_W-1:0]        r_s4_class;
    logic signed [VALUE_W-1:0] r_s4_score;

    always_comb begin
        room_w = r_s3_w - DIM_W'(r_s3_x);
        room_h = r_s3_h - DIM_W'(r_s3_y);
        if (r_s3_rw < SIZE_W'(1)) begin
            n_s4_bw = DIM_W'(1);
        end else if (r_s3_rw > $signed(SIZE_W'(room_w))) begin
            n_s4_bw = room_w;
        end else begin
            n_s4_bw = r_s3_rw[DIM_W-1:0];
        end
        if (r_s3_rh < SIZE_W'(1)) begin
            n_s4_bh = DIM_W'(1);
        end else if (r_s3_rh > $signed(SIZE_W'(room_h))) begin
            n_s4_bh = room_h;
        end else begin
            n_s4_bh = r_s3_rh[DIM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (adv4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r_s4_x     <= r_s3_x;
            r_s4_y     <= r_s3_y;
            r_s4_bw    <= n_s4_bw;
            r_s4_bh    <= n_s4_bh;
            r_s4_imgw  <= r_s3_w;
            r_s4_class <= r_s3_class;
            r_s4_score <= r_s3_score;
        end
    end

    assign o_m_axis_tvalid = r_v4;
    assign o_m_axis_tdata  = {7'd0, r_s4_bh, r_s4_bw, r_s4_y, r_s4_x,
                              r_s4_score, r_s4_class};

    // Row position never runs past the longest row
    `DRD_ASSERT(a_pos_range, i_clk, i_rst_n, r_pos <= POS_MAX_LAST, "row position out of range")
    // A kept row end enters the pipeline on the next edge
    `DRD_ASSERT(a_row_enters, i_clk, i_rst_n, (in_xfer && row_end && row_keep) |=> r_v1, "kept row lost at stage 1")
    // A presented box lies inside the image horizontally
    `DRD_ASSERT_NEVER(a_box_fits, i_clk, i_rst_n, r_v4 && (r_s4_bw == '0 || (DIM_W + 1)'(r_s4_x) + (DIM_W + 1)'(r_s4_bw) > (DIM_W + 1)'(r_s4_imgw)), "box outside image")

endmodule
